// ----- sv/periodic_deadline_catch_up_top_assert.svh -----
// assertion macros for the deadline catch-up block
`ifndef PERIODIC_DEADLINE_CATCH_UP_TOP_ASSERT_SVH
`define PERIODIC_DEADLINE_CATCH_UP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, held off during reset
`define PDCU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, held off during reset
`define PDCU_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PDCU_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define PDCU_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- sv/pdcu_pkg.sv -----
// shared widths and types for the deadline catch-up block
package pdcu_pkg;

   // fixed field widths of the channels
   localparam int FIELD_WIDTH    = 64;
   localparam int PERIOD_WIDTH   = 63;
   localparam int LATE_WIDTH     = 63;
   localparam int TIME_WIDTH_DEF = 64;

   // control bits that travel with each beat down the pipe
   typedef struct packed {
      logic valid;
      logic early;
   } pdcu_ctl_type;

   // one finished result beat
   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] next_deadline;
      logic [FIELD_WIDTH-1:0]        owed_count;
      logic [LATE_WIDTH-1:0]         late_ticks;
      logic                          deadline_saturated;
   } pdcu_result_type;

endpackage

// ----- sv/pdcu_if.sv -----
// channel interfaces: request, response and period write
interface pdcu_req_if;
   import pdcu_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [FIELD_WIDTH-1:0] due_time;
   logic signed [FIELD_WIDTH-1:0] now_time;
   modport source (output valid, output due_time, output now_time, input ready);
   modport sink (input valid, input due_time, input now_time, output ready);
endinterface

interface pdcu_rsp_if;
   import pdcu_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [FIELD_WIDTH-1:0] next_deadline;
   logic [FIELD_WIDTH-1:0]        owed_count;
   logic [LATE_WIDTH-1:0]         late_ticks;
   logic                          deadline_saturated;
   modport source (output valid, output next_deadline, output owed_count,
                   output late_ticks, output deadline_saturated, input ready);
   modport sink (input valid, input next_deadline, input owed_count,
                 input late_ticks, input deadline_saturated, output ready);
endinterface

interface pdcu_csr_if;
   import pdcu_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [PERIOD_WIDTH-1:0] period_ticks;
   modport source (output valid, output period_ticks, input ready);
   modport sink (input valid, input period_ticks, output ready);
endinterface

// ----- sv/periodic_deadline_catch_up_top.sv -----
// A beat passes the input register, lateness stage, divider, back stage and result buffer.
// Throughput: one beat per cycle when not stalled, one quotient bit per divider stage.
// A period write is taken only while no beat is in flight.
// Reset clears all valid bits, the result buffer and the in-flight count,
// and sets the period to 0, which marks it invalid.
module periodic_deadline_catch_up_top #(
   parameter int TIME_WIDTH = pdcu_pkg::TIME_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   pdcu_req_if.sink    req_chan,
   pdcu_rsp_if.source  rsp_chan,
   pdcu_csr_if.sink    csr_chan
);
   import pdcu_pkg::*;

   `include "periodic_deadline_catch_up_top_assert.svh"

   localparam int INFLIGHT_WIDTH = $clog2(TIME_WIDTH + 5);
   localparam logic [FIELD_WIDTH-1:0] MAX_TIME_EXT =
      {{(FIELD_WIDTH-TIME_WIDTH+1){1'b0}}, {(TIME_WIDTH-1){1'b1}}};

   logic [TIME_WIDTH-2:0]     step_ff;
   logic [INFLIGHT_WIDTH-1:0] inflight_ff;
   logic                      csr_fire;
   logic                      req_fire;
   logic                      rsp_fire;
   logic                      adv;
   pdcu_ctl_type              f_ctl;
   logic [TIME_WIDTH-1:0]     f_base;
   logic [TIME_WIDTH-1:0]     f_late;
   logic [TIME_WIDTH-2:0]     f_lsat;
   pdcu_ctl_type              d_ctl;
   logic [TIME_WIDTH-1:0]     d_base;
   logic [TIME_WIDTH-2:0]     d_lsat;
   logic [TIME_WIDTH-1:0]     d_quot;
   logic [TIME_WIDTH-2:0]     d_rem;
   logic                      push;
   pdcu_result_type           res;

   // period register, written only with nothing in flight
   assign csr_chan.ready = (inflight_ff == '0);
   assign csr_fire       = csr_chan.valid && csr_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = rsp_chan.valid && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (csr_fire) begin
         step_ff <= csr_chan.period_ticks[TIME_WIDTH-2:0];
      end
   end

   // beats accepted but not yet delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         unique case ({req_fire, rsp_fire})
            2'b10:   inflight_ff <= inflight_ff + INFLIGHT_WIDTH'(1);
            2'b01:   inflight_ff <= inflight_ff - INFLIGHT_WIDTH'(1);
            default: inflight_ff <= inflight_ff;
         endcase
      end
   end

   pdcu_front #(.TIME_WIDTH(TIME_WIDTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .csr_fire (csr_fire),
      .req_chan (req_chan),
      .ctl_out  (f_ctl),
      .base_out (f_base),
      .late_out (f_late),
      .lsat_out (f_lsat)
   );

   pdcu_divider #(.TIME_WIDTH(TIME_WIDTH)) u_divider (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .step     (step_ff),
      .ctl_in   (f_ctl),
      .base_in  (f_base),
      .late_in  (f_late),
      .lsat_in  (f_lsat),
      .ctl_out  (d_ctl),
      .base_out (d_base),
      .lsat_out (d_lsat),
      .quot_out (d_quot),
      .rem_out  (d_rem)
   );

   pdcu_back #(.TIME_WIDTH(TIME_WIDTH)) u_back (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .step    (step_ff),
      .ctl_in  (d_ctl),
      .base_in (d_base),
      .lsat_in (d_lsat),
      .quot_in (d_quot),
      .rem_in  (d_rem),
      .push    (push),
      .res_out (res)
   );

   pdcu_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .res_in   (res),
      .adv      (adv),
      .rsp_chan (rsp_chan)
   );

   // checks
   `PDCU_ASSERT_IMP(a_sat_is_max, clock, reset, rsp_chan.valid && rsp_chan.deadline_saturated, rsp_chan.next_deadline == MAX_TIME_EXT, "saturated deadline is not the largest time")
   `PDCU_ASSERT_IMP(a_not_late_owes_one, clock, reset, rsp_chan.valid && (rsp_chan.late_ticks == '0), rsp_chan.owed_count == FIELD_WIDTH'(1), "beat that is not late owes other than one period")
   `PDCU_ASSERT_IMP(a_rsp_counted, clock, reset, rsp_chan.valid, inflight_ff != '0, "response beat with nothing in flight")
   `PDCU_ASSERT_NXT(a_csr_when_empty, clock, reset, csr_fire, !rsp_chan.valid, "period write while a result is pending")

endmodule

// ----- sv/pdcu_front.sv -----
// input register and lateness stage
module pdcu_front #(
   parameter int TIME_WIDTH = pdcu_pkg::TIME_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    csr_fire,
   pdcu_req_if.sink                req_chan,
   output pdcu_pkg::pdcu_ctl_type  ctl_out,
   output logic [TIME_WIDTH-1:0]   base_out,
   output logic [TIME_WIDTH-1:0]   late_out,
   output logic [TIME_WIDTH-2:0]   lsat_out
);
   import pdcu_pkg::*;

   logic                  req_fire;
   logic                  v0_ff;
   logic [TIME_WIDTH-1:0] due0_ff;
   logic [TIME_WIDTH-1:0] now0_ff;
   logic [TIME_WIDTH-1:0] diff;
   logic                  early;
   logic                  after;
   logic [TIME_WIDTH-2:0] lsat_in;
   logic                  v1_ff;
   logic                  early1_ff;
   logic [TIME_WIDTH-1:0] base1_ff;
   logic [TIME_WIDTH-1:0] late1_ff;
   logic [TIME_WIDTH-2:0] lsat1_ff;

   // the input register fills whenever it is empty, even while the pipe waits, unless a period write is taken
   assign req_chan.ready = (adv || !v0_ff) && !csr_fire;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv || !v0_ff) begin
         v0_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         due0_ff <= req_chan.due_time[TIME_WIDTH-1:0];
         now0_ff <= req_chan.now_time[TIME_WIDTH-1:0];
      end
   end

   // order of the two times and the lateness
   assign diff  = now0_ff - due0_ff;
   assign early = $signed(now0_ff) < $signed(due0_ff);
   assign after = $signed(now0_ff) > $signed(due0_ff);

   // lateness clamped to the largest time
   always_comb begin
      if (!after) begin
         lsat_in = '0;
      end else if (diff[TIME_WIDTH-1] || (&diff[TIME_WIDTH-2:0])) begin
         lsat_in = {(TIME_WIDTH-1){1'b1}};
      end else begin
         lsat_in = diff[TIME_WIDTH-2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v0_ff;
      end
   end

   // a beat that is early only needs its due time, so one word carries both
   always_ff @(posedge clock) begin
      if (adv) begin
         early1_ff <= early;
         base1_ff  <= early ? due0_ff : now0_ff;
         late1_ff  <= diff;
         lsat1_ff  <= lsat_in;
      end
   end

   assign ctl_out  = '{valid: v1_ff, early: early1_ff};
   assign base_out = base1_ff;
   assign late_out = late1_ff;
   assign lsat_out = lsat1_ff;

endmodule

// ----- sv/pdcu_divider.sv -----
// restoring divider, one quotient bit per pipeline stage
module pdcu_divider #(
   parameter int TIME_WIDTH = pdcu_pkg::TIME_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic [TIME_WIDTH-2:0]   step,
   input  pdcu_pkg::pdcu_ctl_type  ctl_in,
   input  logic [TIME_WIDTH-1:0]   base_in,
   input  logic [TIME_WIDTH-1:0]   late_in,
   input  logic [TIME_WIDTH-2:0]   lsat_in,
   output pdcu_pkg::pdcu_ctl_type  ctl_out,
   output logic [TIME_WIDTH-1:0]   base_out,
   output logic [TIME_WIDTH-2:0]   lsat_out,
   output logic [TIME_WIDTH-1:0]   quot_out,
   output logic [TIME_WIDTH-2:0]   rem_out
);
   import pdcu_pkg::*;

   pdcu_ctl_type          ctl_ff  [TIME_WIDTH];
   logic [TIME_WIDTH-1:0] base_ff [TIME_WIDTH];
   logic [TIME_WIDTH-2:0] lsat_ff [TIME_WIDTH];
   logic [TIME_WIDTH-2:0] rem_ff  [TIME_WIDTH];
   logic [TIME_WIDTH-1:0] dq_ff   [TIME_WIDTH];

   for (genvar k = 0; k < TIME_WIDTH; k++) begin : g_stage
      pdcu_ctl_type          ctl_src;
      logic [TIME_WIDTH-1:0] base_src;
      logic [TIME_WIDTH-2:0] lsat_src;
      logic [TIME_WIDTH-2:0] rem_src;
      logic [TIME_WIDTH-1:0] dq_src;
      logic [TIME_WIDTH-1:0] trial;
      logic [TIME_WIDTH-1:0] trial_sub;
      logic                  ge;
      logic [TIME_WIDTH-2:0] rem_in;
      logic [TIME_WIDTH-1:0] dq_in;

      // stage inputs: the front end for the first step, else the step above
      if (k == 0) begin : g_first
         assign ctl_src  = ctl_in;
         assign base_src = base_in;
         assign lsat_src = lsat_in;
         assign rem_src  = '0;
         assign dq_src   = late_in;
      end else begin : g_rest
         assign ctl_src  = ctl_ff[k-1];
         assign base_src = base_ff[k-1];
         assign lsat_src = lsat_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign dq_src   = dq_ff[k-1];
      end

      // shift in the next dividend bit, subtract the period if it fits
      assign trial     = {rem_src, dq_src[TIME_WIDTH-1]};
      assign trial_sub = trial - {1'b0, step};
      assign ge        = trial >= {1'b0, step};
      assign rem_in    = ge ? trial_sub[TIME_WIDTH-2:0] : trial[TIME_WIDTH-2:0];
      assign dq_in     = {dq_src[TIME_WIDTH-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k] <= '0;
         end else if (adv) begin
            ctl_ff[k] <= ctl_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            base_ff[k] <= base_src;
            lsat_ff[k] <= lsat_src;
            rem_ff[k]  <= rem_in;
            dq_ff[k]   <= dq_in;
         end
      end
   end

   assign ctl_out  = ctl_ff[TIME_WIDTH-1];
   assign base_out = base_ff[TIME_WIDTH-1];
   assign lsat_out = lsat_ff[TIME_WIDTH-1];
   assign quot_out = dq_ff[TIME_WIDTH-1];
   assign rem_out  = rem_ff[TIME_WIDTH-1];

endmodule

// ----- sv/pdcu_back.sv -----
// grid gap, headroom and owed count, then final result select
module pdcu_back #(
   parameter int TIME_WIDTH = pdcu_pkg::TIME_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic [TIME_WIDTH-2:0]     step,
   input  pdcu_pkg::pdcu_ctl_type    ctl_in,
   input  logic [TIME_WIDTH-1:0]     base_in,
   input  logic [TIME_WIDTH-2:0]     lsat_in,
   input  logic [TIME_WIDTH-1:0]     quot_in,
   input  logic [TIME_WIDTH-2:0]     rem_in,
   output logic                      push,
   output pdcu_pkg::pdcu_result_type res_out
);
   import pdcu_pkg::*;

   localparam logic [TIME_WIDTH-1:0] TMAX = {1'b0, {(TIME_WIDTH-1){1'b1}}};

   logic [TIME_WIDTH-2:0]  gap_in;
   logic [TIME_WIDTH-1:0]  room_in;
   logic [FIELD_WIDTH-1:0] owed_in;
   logic                   v_ff;
   logic                   early_ff;
   logic                   inval_ff;
   logic [TIME_WIDTH-2:0]  gap_ff;
   logic [TIME_WIDTH-1:0]  room_ff;
   logic [FIELD_WIDTH-1:0] owed_ff;
   logic [TIME_WIDTH-1:0]  base_ff;
   logic [TIME_WIDTH-2:0]  lsat_ff;
   logic                   over;
   logic [TIME_WIDTH-1:0]  sum;
   logic [TIME_WIDTH-1:0]  next_tw;

   // distance to the next grid point and room left below the largest time
   assign gap_in  = (rem_in == '0) ? step : step - rem_in;
   assign room_in = TMAX - base_in;
   assign owed_in = FIELD_WIDTH'(quot_in) + FIELD_WIDTH'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (adv) begin
         v_ff <= ctl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         early_ff <= ctl_in.early;
         inval_ff <= (step == '0);
         gap_ff   <= gap_in;
         room_ff  <= room_in;
         owed_ff  <= owed_in;
         base_ff  <= base_in;
         lsat_ff  <= lsat_in;
      end
   end

   // clamp check and grid deadline side by side
   assign over = {1'b0, gap_ff} > room_ff;
   assign sum  = base_ff + {1'b0, gap_ff};

   always_comb begin
      res_out.late_ticks         = LATE_WIDTH'(lsat_ff);
      res_out.owed_count         = owed_ff;
      res_out.deadline_saturated = 1'b0;
      next_tw                    = sum;
      priority if (inval_ff) begin
         next_tw            = TMAX;
         res_out.owed_count = FIELD_WIDTH'(1);
      end else if (early_ff) begin
         next_tw            = base_ff;
         res_out.owed_count = FIELD_WIDTH'(1);
      end else if (over) begin
         next_tw                    = TMAX;
         res_out.deadline_saturated = 1'b1;
      end else begin
         next_tw = sum;
      end
      res_out.next_deadline = FIELD_WIDTH'($signed(next_tw));
   end

   assign push = v_ff && adv;

endmodule

// ----- sv/pdcu_out_buf.sv -----
// two-entry result buffer that decouples the pipe from the response side
module pdcu_out_buf (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  pdcu_pkg::pdcu_result_type res_in,
   output logic                      adv,
   pdcu_rsp_if.source                rsp_chan
);
   import pdcu_pkg::*;

   logic [1:0]      count_ff;
   pdcu_result_type slot0_ff;
   pdcu_result_type slot1_ff;
   logic            pop;

   assign pop = rsp_chan.valid && rsp_chan.ready;

   // pipe moves while a slot is free
   assign adv = (count_ff != 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   // head slot drives the response, second slot catches a beat during a stall
   always_ff @(posedge clock) begin
      if (push && ((count_ff == 2'd0) || ((count_ff == 2'd1) && pop))) begin
         slot0_ff <= res_in;
      end else if (pop) begin
         slot0_ff <= slot1_ff;
      end
      if (push && (count_ff == 2'd1) && !pop) begin
         slot1_ff <= res_in;
      end
   end

   assign rsp_chan.valid              = (count_ff != 2'd0);
   assign rsp_chan.next_deadline      = slot0_ff.next_deadline;
   assign rsp_chan.owed_count         = slot0_ff.owed_count;
   assign rsp_chan.late_ticks         = slot0_ff.late_ticks;
   assign rsp_chan.deadline_saturated = slot0_ff.deadline_saturated;

endmodule

// ----- tb/tb_periodic_deadline_catch_up_top.sv -----
// self-checking testbench for the periodic deadline catch-up block
module tb_periodic_deadline_catch_up_top;
   import pdcu_pkg::*;

   localparam logic [63:0] TIME_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] TIME_MIN = 64'h8000_0000_0000_0000;
   localparam logic [62:0] PERIOD_MAX = '1;
   localparam int unsigned RUN_LIMIT_CYCLES = 200000;
   localparam int SEGMENT_ITEMS = 275;

   // one request beat: a due time and the current time
   typedef struct {
      logic [63:0] due;
      logic [63:0] now;
   } deadline_query_type;

   logic clock;
   logic reset;

   pdcu_req_if req_chan();
   pdcu_rsp_if rsp_chan();
   pdcu_csr_if csr_chan();

   periodic_deadline_catch_up_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   deadline_query_type pending_queries[$];
   pdcu_result_type    expected_deadlines[$];
   deadline_query_type offered_query;
   pdcu_result_type    oldest_deadline;
   logic [62:0]        active_period = '0;
   int                 send_idle_pct = 25;
   int                 recv_stall_pct = 60;
   int                 rsp_hold_left = 0;
   int                 mismatch_count = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #(RUN_LIMIT_CYCLES * 12);
      $display("FAIL periodic_deadline_catch_up_top");
      $finish;
   end

   // next deadline, periods owed and lateness for one query
   function automatic pdcu_result_type predict_deadline(input logic [63:0] due,
                                                        input logic [63:0] now,
                                                        input logic [62:0] period);
      logic [63:0]     step;
      logic [63:0]     late;
      logic [63:0]     rem;
      logic [63:0]     gap;
      logic [63:0]     room;
      logic            is_before;
      logic            is_after;
      pdcu_result_type res;
      step = {1'b0, period};
      is_before = $signed(now) < $signed(due);
      is_after = $signed(now) > $signed(due);
      late = now - due;
      res.late_ticks = is_after ? ((late < TIME_MAX) ? late[62:0] : TIME_MAX[62:0]) : '0;
      res.deadline_saturated = 1'b0;
      res.owed_count = 64'd1;
      if (step == 64'd0) begin
         res.next_deadline = TIME_MAX;
      end else if (is_before) begin
         res.next_deadline = due;
      end else begin
         // distance to the next grid point strictly after now
         rem = late % step;
         gap = (rem == 64'd0) ? step : step - rem;
         room = TIME_MAX - now;
         if (gap > room) begin
            res.next_deadline = TIME_MAX;
            res.deadline_saturated = 1'b1;
         end else begin
            res.next_deadline = now + gap;
         end
         res.owed_count = 64'd1 + late / step;
      end
      return res;
   endfunction

   // random query biased toward the grid, the top of time and the corners
   function automatic deadline_query_type make_query(input logic [62:0] period);
      deadline_query_type q;
      logic [63:0]        span;
      logic [63:0]        bump;
      logic [63:0]        corner [4];
      corner = '{TIME_MIN, TIME_MAX, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF};
      span = (period == '0) ? 64'd1000 : {1'b0, period};
      q.due = {$urandom, $urandom};
      q.now = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: bump = 64'd0;
         1: bump = 64'd1;
         2: bump = span - 64'd1;
         default: bump = {$urandom, $urandom} % span;
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2: ;
         3, 4, 5: q.now = q.due + span * $urandom_range(0, 20) + bump;
         6: q.now = q.due - ({$urandom, $urandom} % 64'd5000 + 64'd1);
         7: begin
            q.now = TIME_MAX - $urandom_range(0, 2000);
            q.due = q.now - (span * $urandom_range(0, 4) + bump);
         end
         8: q.now = q.due;
         default: begin
            q.due = corner[$urandom_range(0, 3)];
            q.now = corner[$urandom_range(0, 3)];
         end
      endcase
      return q;
   endfunction

   // mismatch report
   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("mismatch at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string field, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         flag_mismatch($sformatf("%s got %h want %h", field, got, want));
   endtask

   task automatic queue_query(input logic [63:0] due, input logic [63:0] now);
      deadline_query_type q;
      q.due = due;
      q.now = now;
      pending_queries.push_back(q);
   endtask

   // hold until every queued query has been answered
   task automatic wait_drained();
      while (pending_queries.size() != 0 || req_chan.valid || expected_deadlines.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_period(input logic [62:0] value);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.period_ticks <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      active_period = value;
   endtask

   // request driver fed from the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (pending_queries.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            offered_query = pending_queries.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.due_time <= offered_query.due;
            req_chan.now_time <= offered_query.now;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // response ready with random stalls and long hold-offs
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_hold_left != 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // monitor: check response beats, predict accepted request beats
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_deadlines.size() == 0) begin
               flag_mismatch($sformatf("unexpected beat next_deadline %h",
                                       rsp_chan.next_deadline));
            end else begin
               oldest_deadline = expected_deadlines.pop_front();
               check_field("next_deadline", rsp_chan.next_deadline,
                           oldest_deadline.next_deadline);
               check_field("owed_count", rsp_chan.owed_count, oldest_deadline.owed_count);
               check_field("late_ticks", {1'b0, rsp_chan.late_ticks},
                           {1'b0, oldest_deadline.late_ticks});
               check_field("deadline_saturated", {63'd0, rsp_chan.deadline_saturated},
                           {63'd0, oldest_deadline.deadline_saturated});
            end
         end
         if (req_chan.valid && req_chan.ready)
            expected_deadlines.push_back(predict_deadline(req_chan.due_time,
                                                          req_chan.now_time, active_period));
      end
   end

   // stimulus
   initial begin
      logic [62:0] next_period;
      logic [63:0] wide;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.due_time = '0;
      req_chan.now_time = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.period_ticks = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // invalid period straight after reset
      queue_query(TIME_MIN, TIME_MAX);
      queue_query(TIME_MAX, TIME_MIN);
      queue_query(64'd5, 64'd5);
      queue_query(64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      wait_drained();

      // ordinary period: early, equal, on grid, off grid, clamped, huge lateness
      write_period(63'd1000);
      queue_query(64'd100, 64'd50);
      queue_query(64'd100, 64'd100);
      queue_query(64'd100, 64'd3100);
      queue_query(64'd100, 64'd3150);
      queue_query(TIME_MAX - 64'd500, TIME_MAX - 64'd10);
      queue_query(TIME_MAX - 64'd1000, TIME_MAX);
      queue_query(TIME_MIN, TIME_MAX);
      queue_query(64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
      wait_drained();

      // largest period
      write_period(PERIOD_MAX);
      queue_query(TIME_MIN, TIME_MAX);
      queue_query(64'd0, TIME_MAX);
      queue_query(64'hFFFF_FFFF_FFFF_FFFB, TIME_MAX - 64'd5);
      wait_drained();

      // unit period: owed count wraps, clamp at the very top
      write_period(63'd1);
      queue_query(TIME_MIN, TIME_MAX);
      queue_query(TIME_MAX - 64'd1, TIME_MAX);
      queue_query(TIME_MIN, TIME_MIN + 64'd1);
      wait_drained();

      // random segments, each with its own period, and an idle pattern per pair of segments
      for (int seg = 0; seg < 6; seg++) begin
         wide = {$urandom, $urandom};
         case (seg)
            0: next_period = 63'($urandom_range(1, 16));
            1: next_period = 63'($urandom_range(1, 32'hFFFF_FFFF));
            2: next_period = wide[62:0];
            3: next_period = PERIOD_MAX;
            4: next_period = '0;
            default: next_period = 63'($urandom_range(2, 64));
         endcase
         case (seg / 2)
            0: begin
               send_idle_pct = 25;
               recv_stall_pct = 60;
            end
            1: begin
               send_idle_pct = 60;
               recv_stall_pct = 25;
            end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         write_period(next_period);
         for (int i = 0; i < SEGMENT_ITEMS; i++)
            pending_queries.push_back(make_query(next_period));
         // long receiver hold-off while the sender keeps offering
         if (seg == 0 || seg == 4) begin
            @(negedge clock);
            rsp_hold_left = 400;
         end
         wait_drained();
      end

      repeat (80) @(posedge clock);
      if (mismatch_count == 0 && expected_deadlines.size() == 0)
         $display("PASS periodic_deadline_catch_up_top");
      else
         $display("FAIL periodic_deadline_catch_up_top");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+sv
sv/pdcu_pkg.sv
sv/pdcu_if.sv
sv/pdcu_front.sv
sv/pdcu_divider.sv
sv/pdcu_back.sv
sv/pdcu_out_buf.sv
sv/periodic_deadline_catch_up_top.sv
tb/tb_periodic_deadline_catch_up_top.sv
